@@ hdl/integer_to_ascii_formatter_top_macros.svh @@
// Assertion macros for the formatter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk, off during reset.
`define IFMT_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Next-cycle implication, clocked on clk, off during reset.
`define IFMT_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define IFMT_ASSERT_NOW(lbl, pre, post, msg)
`define IFMT_ASSERT_NXT(lbl, pre, post, msg)
`endif
`endif

@@ hdl/ifmt_pkg.sv @@
// Types, codes and the digit-to-character function of the formatter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ifmt_pkg;

    localparam logic [2:0] ACT_SDEC32 = 3'd0;
    localparam logic [2:0] ACT_UDEC32 = 3'd1;
    localparam logic [2:0] ACT_HEX32L = 3'd2;
    localparam logic [2:0] ACT_HEX32U = 3'd3;
    localparam logic [2:0] ACT_HEX64L = 3'd4;

    localparam logic [7:0] CHR_MINUS = 8'h2d;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_LOW_A = 8'h61;
    localparam logic [7:0] CHR_UP_A  = 8'h41;

    localparam logic [4:0] DEC_DIGITS   = 5'd10;
    localparam logic [4:0] HEX32_DIGITS = 5'd8;
    localparam logic [4:0] HEX64_DIGITS = 5'd16;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] value;
        logic [15:0] count_start;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  character;
        logic        last;
        logic [16:0] count;
    } out_word_t;

    // Classified number handed from front to back.
    typedef struct packed {
        logic        dec;
        logic        wide;
        logic        upper;
        logic        neg;
        logic [63:0] mag;
        logic [15:0] count_start;
    } desc_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } back_state_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] dx;
        dx = {4'b0000, d};
        if (d < 4'd10)
            return CHR_ZERO + dx;
        else
            return (upper ? CHR_UP_A : CHR_LOW_A) + dx - 8'd10;
    endfunction

endpackage
`default_nettype wire

@@ hdl/ifmt_fifo.sv @@
// Two-entry register queue of classified numbers between front and back.
// Depends on ifmt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ifmt_fifo (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               wr_en,
    input  ifmt_pkg::desc_t   wr_data,
    output logic              full,
    output logic              valid,
    input  wire               rd_en,
    output ifmt_pkg::desc_t   rd_data
);
    import ifmt_pkg::*;

    desc_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full    = (fill_reg == 2'd2);
    assign valid   = (fill_reg != 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        fill_next   = fill_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule
`default_nettype wire

@@ hdl/ifmt_front.sv @@
// Front end: accepts numbers, classifies format and sign, queues them.
// Depends on ifmt_pkg and ifmt_fifo.
`timescale 1ns / 1ps
`default_nettype none
module ifmt_front (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  ifmt_pkg::in_word_t item,
    output logic               full,
    output logic               q_valid,
    input  wire                q_take,
    output ifmt_pkg::desc_t    q_word
);
    import ifmt_pkg::*;

    desc_t       desc;
    logic        known;
    logic        wr_en;
    logic [31:0] low32;

    assign low32 = item.value[31:0];

    always_comb
    begin
        desc             = '0;
        desc.count_start = item.count_start;
        known            = 1'b1;
        case (item.action)
            ACT_SDEC32:
            begin
                desc.dec = 1'b1;
                desc.neg = low32[31];
                desc.mag = {32'd0, low32[31] ? (~low32 + 32'd1) : low32};
            end
            ACT_UDEC32:
            begin
                desc.dec = 1'b1;
                desc.mag = {32'd0, low32};
            end
            ACT_HEX32L:
                desc.mag = {32'd0, low32};
            ACT_HEX32U:
            begin
                desc.upper = 1'b1;
                desc.mag   = {32'd0, low32};
            end
            ACT_HEX64L:
            begin
                desc.wide = 1'b1;
                desc.mag  = item.value;
            end
            default:
                known = 1'b0;
        endcase
    end

    // Drop unused selectors: accepted, but nothing queued.
    assign wr_en = push && !full && known;

    ifmt_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (desc),
        .full    (full),
        .valid   (q_valid),
        .rd_en   (q_take),
        .rd_data (q_word)
    );

endmodule
`default_nettype wire

@@ hdl/ifmt_back.sv @@
// Back end: binary to BCD by double dabble, leading-zero skip, character emit.
// Depends on ifmt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_ascii_formatter_top_macros.svh"
module ifmt_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 q_valid,
    input  ifmt_pkg::desc_t     q_word,
    output logic                q_take,
    output logic                empty,
    input  wire                 pop,
    output ifmt_pkg::out_word_t result
);
    import ifmt_pkg::*;

    back_state_t state_reg, state_next;
    logic [63:0] dig_reg;
    logic [31:0] bin_reg;
    logic [4:0]  bit_cnt_reg;
    logic [4:0]  remain_reg;
    logic        neg_reg;
    logic        upper_reg;
    logic [16:0] cnt_reg;
    logic        out_valid_reg;
    out_word_t   out_word_reg;

    logic        slot_free;
    logic        emit_sign;
    logic        emit_digit;
    logic        top_zero;
    logic        last_digit;
    logic [39:0] bcd_adj;
    logic [39:0] bcd_shift;

    assign slot_free  = !out_valid_reg || pop;
    assign top_zero   = (dig_reg[63:60] == 4'd0);
    assign last_digit = (remain_reg == 5'd1);
    assign empty      = !out_valid_reg;
    assign result     = out_word_reg;

    // Add 3 to every BCD nibble of 5 or more, then shift in the next bit.
    always_comb
    begin
        for (int i = 0; i < 10; i++)
        begin
            if (dig_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = dig_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = dig_reg[i*4 +: 4];
        end
        bcd_shift = {bcd_adj[38:0], bin_reg[31]};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (q_valid)
                    state_next = q_word.dec ? ST_DABBLE : ST_SKIP;
            ST_DABBLE:
                if (bit_cnt_reg == 5'd31)
                    state_next = ST_SKIP;
            ST_SKIP:
                if (!(top_zero && !last_digit))
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
            ST_SIGN:
                if (slot_free)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (slot_free && last_digit)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_take     = 1'b0;
        emit_sign  = 1'b0;
        emit_digit = 1'b0;
        case (state_reg)
            ST_IDLE: q_take     = q_valid;
            ST_SIGN: emit_sign  = slot_free;
            ST_EMIT: emit_digit = slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_sign || emit_digit)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            neg_reg     <= q_word.neg;
            upper_reg   <= q_word.upper;
            cnt_reg     <= {1'b0, q_word.count_start};
            bin_reg     <= q_word.mag[31:0];
            bit_cnt_reg <= 5'd0;
            if (q_word.dec)
            begin
                dig_reg    <= 64'd0;
                remain_reg <= DEC_DIGITS;
            end
            else if (q_word.wide)
            begin
                dig_reg    <= q_word.mag;
                remain_reg <= HEX64_DIGITS;
            end
            else
            begin
                dig_reg    <= {q_word.mag[31:0], 32'd0};
                remain_reg <= HEX32_DIGITS;
            end
        end
        if (state_reg == ST_DABBLE)
        begin
            bin_reg     <= {bin_reg[30:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg + 5'd1;
            // Park the ten digits at the top once the last bit is in.
            if (bit_cnt_reg == 5'd31)
                dig_reg <= {bcd_shift, 24'd0};
            else
                dig_reg <= {24'd0, bcd_shift};
        end
        if (state_reg == ST_SKIP && top_zero && !last_digit)
        begin
            dig_reg    <= {dig_reg[59:0], 4'd0};
            remain_reg <= remain_reg - 5'd1;
        end
        if (emit_sign)
        begin
            out_word_reg.character <= CHR_MINUS;
            out_word_reg.last      <= 1'b0;
            out_word_reg.count     <= cnt_reg + 17'd1;
            cnt_reg                <= cnt_reg + 17'd1;
        end
        if (emit_digit)
        begin
            out_word_reg.character <= digit_char(dig_reg[63:60], upper_reg);
            out_word_reg.last      <= last_digit;
            out_word_reg.count     <= cnt_reg + 17'd1;
            cnt_reg                <= cnt_reg + 17'd1;
            dig_reg                <= {dig_reg[59:0], 4'd0};
            remain_reg             <= remain_reg - 5'd1;
        end
    end

    `IFMT_ASSERT_NXT(a_dabble_runs, (state_reg == ST_DABBLE && bit_cnt_reg != 5'd31), (state_reg == ST_DABBLE), "double dabble left early")
    `IFMT_ASSERT_NOW(a_emit_remain, (state_reg == ST_EMIT || state_reg == ST_SKIP), (remain_reg != 5'd0), "no digits left while emitting")
    `IFMT_ASSERT_NOW(a_sign_neg, (state_reg == ST_SIGN), neg_reg, "minus sign for a non-negative number")
    `IFMT_ASSERT_NXT(a_count_load, q_take, (cnt_reg == {1'b0, $past(q_word.count_start)}), "start count not loaded")

endmodule
`default_nettype wire

@@ hdl/integer_to_ascii_formatter_top.sv @@
// Top level of the integer to ASCII formatter.
// Depends on ifmt_pkg, ifmt_front and ifmt_back.
`timescale 1ns / 1ps
`default_nettype none
// Each word pushed in carries a value, a format selector and a start count; the
// block pops out the number as ASCII characters, most significant first, without
// leading zeros, with last set on the final character and count equal to the
// start count plus the characters delivered so far. Selectors 0..4 give signed
// decimal (leading minus, most negative value included), unsigned decimal,
// lower and upper 32-bit hex and lower 64-bit hex; other selectors are taken
// and give nothing. A two-word queue parts the input side from the converter,
// so pushes go on while a number is worked out. Steps per number: a decimal
// number is loaded, run through double dabble (one bit a cycle), has its
// leading zeros skipped (up to 9), leaves the skip, emits a minus sign if
// negative and then one character per digit; a hex number is loaded, has its
// leading zeros skipped (up to 7 or 15), leaves the skip and emits one
// character per digit. The converter handles one number at a time, and a
// character that is not popped holds up the sign and digit steps.
module integer_to_ascii_formatter_top (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  ifmt_pkg::in_word_t  item,
    output logic                full,
    output logic                empty,
    input  wire                 pop,
    output ifmt_pkg::out_word_t result
);
    import ifmt_pkg::*;

    // Queue hand-off between classifier and converter.
    logic  q_valid;
    logic  q_take;
    desc_t q_word;

    ifmt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .q_valid (q_valid),
        .q_take  (q_take),
        .q_word  (q_word)
    );

    // Convert, skip leading zeros, hold each character until popped.
    ifmt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_take  (q_take),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking bench for integer_to_ascii_formatter_top: drives numbers in and checks each
// popped character against a predicted spelling of the number.
// Depends on ifmt_pkg and the formatter RTL only.
`timescale 1ns / 1ps

module testbench;

    import ifmt_pkg::*;

    // Selectors that the block takes but spells nothing for.
    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_MID   = 3'd6;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    localparam int RADIX_DEC = 10;
    localparam int RADIX_HEX = 16;

    localparam int RANDOM_WORDS = 330;
    localparam int MAX_GAP      = 13;
    // Many times the span of one decimal number of its own plus the longest gap
    // on each side.
    localparam int QUIET_LIMIT  = 2000;
    // Covers a full decimal conversion plus a few spare cycles.
    localparam int DRAIN_CYCLES = 80;

    // Holds the characters still owed by the block, oldest first.
    class char_tracker;
        out_word_t pending[$];
        int        faults;

        function new();
            faults = 0;
        endfunction

        // Spell an accepted number into the characters it must come out as.
        function void spell_number(in_word_t w);
            logic [63:0] mag;
            logic [31:0] low32;
            int          base;
            bit          neg;
            string       digits;
            logic [7:0]  text[$];
            out_word_t   c;
            low32  = w.value[31:0];
            neg    = 1'b0;
            base   = RADIX_HEX;
            digits = "0123456789abcdef";
            case (w.action)
                ACT_SDEC32:
                begin
                    base = RADIX_DEC;
                    neg  = low32[31];
                    mag  = {32'd0, neg ? (~low32 + 32'd1) : low32};
                end
                ACT_UDEC32:
                begin
                    base = RADIX_DEC;
                    mag  = {32'd0, low32};
                end
                ACT_HEX32L: mag = {32'd0, low32};
                ACT_HEX32U:
                begin
                    mag    = {32'd0, low32};
                    digits = "0123456789ABCDEF";
                end
                ACT_HEX64L: mag = w.value;
                default: return;
            endcase
            do
            begin
                text.push_front(digits[mag % base]);
                mag = mag / base;
            end while (mag != 64'd0);
            if (neg)
                text.push_front("-");
            foreach (text[i])
            begin
                c.character = text[i];
                c.last      = (i == text.size() - 1);
                c.count     = {1'b0, w.count_start} + 17'(i + 1);
                pending.push_back(c);
            end
        endfunction

        // Compare a popped character with the oldest one owed.
        function void check_char(out_word_t got);
            out_word_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: character %h popped with none owed", $time, got);
                faults++;
                return;
            end
            want = pending.pop_front();
            if (got.character !== want.character)
            begin
                $display("%0t: character expected %h actual %h",
                         $time, want.character, got.character);
                faults++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                faults++;
            end
            if (got.count !== want.count)
            begin
                $display("%0t: count expected %h actual %h", $time, want.count, got.count);
                faults++;
            end
        endfunction
    endclass

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      pop   = 1'b0;
    in_word_t  item  = '0;
    logic      full;
    logic      empty;
    out_word_t result;

    // When set, both sides stop idling so words go back to back.
    bit steady = 1'b0;

    char_tracker book = new();

    integer_to_ascii_formatter_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Push one number. Idle first for a drawn number of cycles, then hold push
    // until the block takes the word. Leave push high on return: the caller
    // either pushes the next word or drops push in this same time step.
    task automatic push_number(input logic [2:0] act, input logic [63:0] v,
                               input logic [15:0] cs);
        in_word_t w;
        int       gap;
        w.action      = act;
        w.value       = v;
        w.count_start = cs;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= w;
        @(posedge clk);
        while (full !== 1'b0)
            @(posedge clk);
        book.spell_number(w);
    endtask

    // Drop push and hold off until every owed character has been popped.
    task automatic wait_drained();
        push <= 1'b0;
        while (book.pending.size() != 0)
            @(posedge clk);
    endtask

    // Pop side: idle a drawn number of cycles per character, then take the next
    // character as soon as one is waiting.
    initial
    begin : pop_side
        int gap;
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty !== 1'b0)
                @(posedge clk);
            book.check_char(result);
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        logic [2:0]  act;
        logic [63:0] v;
        logic [63:0] p;
        logic [15:0] cs;
        int          k;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: zero in every format, sign edges, the most negative
        // value, all-ones, high bits that the 32-bit formats must ignore,
        // start counts at both ends, and the spare selectors.
        push_number(ACT_SDEC32, 64'h0, 16'h1234);
        push_number(ACT_SDEC32, 64'h1, 16'h0000);
        push_number(ACT_SDEC32, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        push_number(ACT_SDEC32, 64'h0000_0000_7FFF_FFFF, 16'h0007);
        push_number(ACT_SDEC32, 64'h0000_0000_8000_0000, 16'hFFF0);
        push_number(ACT_SDEC32, 64'h5A5A_5A5A_FFFF_FF00, 16'h0000);
        push_number(ACT_UDEC32, 64'h0, 16'hFFFF);
        push_number(ACT_UDEC32, 64'h0000_0000_FFFF_FFFF, 16'h0064);
        push_number(ACT_UDEC32, 64'hA5A5_A5A5_3B9A_CA00, 16'h0000);
        push_number(ACT_HEX32L, 64'h0, 16'h0001);
        push_number(ACT_HEX32L, 64'h1234_5678_DEAD_BEEF, 16'hFFFF);
        push_number(ACT_HEX32L, 64'h0000_0000_FFFF_FFFF, 16'h0000);
        push_number(ACT_HEX32U, 64'h0000_0000_ABCD_EF09, 16'h8000);
        push_number(ACT_HEX32U, 64'hFFFF_FFFF_0000_0000, 16'h5555);
        push_number(ACT_HEX64L, 64'h0, 16'h0000);
        push_number(ACT_HEX64L, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        push_number(ACT_HEX64L, 64'h0123_4567_89AB_CDEF, 16'h2AAA);
        push_number(ACT_HEX64L, 64'h1, 16'hFFFF);
        push_number(ACT_HEX64L, 64'h8000_0000_0000_0000, 16'h0003);
        push_number(ACT_SPARE_FIRST, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        push_number(ACT_SPARE_MID, 64'h0, 16'h0000);
        push_number(ACT_SPARE_LAST, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);

        // Hold the sender until the block has emptied out.
        wait_drained();

        for (k = 0; k < RANDOM_WORDS; k++)
        begin
            // Flip now and then into a back-to-back stretch and out again.
            if ($urandom_range(0, 39) == 0)
                steady = !steady;

            if ($urandom_range(0, 19) == 0)
                act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
            else
                act = 3'($urandom_range(ACT_SDEC32, ACT_HEX64L));

            // Mix the value shapes so every digit count shows up.
            case ($urandom_range(0, 5))
                0: v = {$urandom, $urandom};
                1: v = 64'($urandom_range(0, 20));
                2: v = {$urandom, $urandom} >> $urandom_range(0, 63);
                3:
                begin
                    case ($urandom_range(0, 3))
                        0: v = 64'h0000_0000_8000_0000;
                        1: v = 64'h0000_0000_7FFF_FFFF;
                        2: v = 64'h0000_0000_FFFF_FFFF;
                        default: v = 64'hFFFF_FFFF_FFFF_FFFF;
                    endcase
                end
                4:
                begin
                    // Step across a power of ten.
                    p = 64'd1;
                    repeat ($urandom_range(0, 9)) p = p * RADIX_DEC;
                    v = p + 64'($urandom_range(0, 2)) - 64'd1;
                end
                default:
                begin
                    v = '0;
                    v[31:0] = 32'd0 - 32'($urandom_range(1, 1000));
                end
            endcase
            // Fill the ignored upper half for the 32-bit formats.
            if (act != ACT_HEX64L && $urandom_range(0, 1) == 1)
                v[63:32] = $urandom;

            if ($urandom_range(0, 7) == 0)
                cs = 16'hFFFF - 16'($urandom_range(0, 15));
            else
                cs = 16'($urandom);

            push_number(act, v, cs);
        end

        wait_drained();
        // Give a spare-selector word time to clear and catch stray characters.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (book.pending.size() != 0)
            $display("%0t: %0d characters never popped", $time, book.pending.size());
        if (book.faults == 0 && book.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ integer_to_ascii_formatter_top.f @@
+incdir+hdl
hdl/ifmt_pkg.sv
hdl/ifmt_fifo.sv
hdl/ifmt_front.sv
hdl/ifmt_back.sv
hdl/integer_to_ascii_formatter_top.sv
sim/testbench.sv
